// File: rtl/core/rsca_pkg.sv
`default_nettype none

package rsca_pkg;

    localparam int COORD_W = 6;
    localparam int FILL_W = 7;
    localparam int THR_W = 4;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam int GRID_WIDTH_DEFAULT = 64;
    localparam int GRID_HEIGHT_DEFAULT = 64;

    localparam logic [FILL_W-1:0] FILL_RESET = 7'd45;
    localparam logic [THR_W-1:0] THR_RESET = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_PERCENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_THRESHOLD = 1'b1;

    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [FILL_W-1:0]  roll;
    } item_t;

    typedef struct packed {
        logic               cell_after;
        logic [COUNT_W-1:0] wall_count;
        logic               changed;
    } result_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill_percent;
        logic [THR_W-1:0]  neighbor_threshold;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/rsca_ram.sv
`default_nettype none

module rsca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rsca_cfg.sv
`default_nettype none

module rsca_cfg
    import rsca_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_percent <= FILL_RESET;
            cfg_reg.neighbor_threshold <= THR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FILL_PERCENT:
                begin
                    cfg_reg.fill_percent <= cfg_data[FILL_W-1:0];
                end
                CFG_NEIGHBOR_THRESHOLD:
                begin
                    cfg_reg.neighbor_threshold <= cfg_data[THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/rsca_engine.sv
`default_nettype none

module rsca_engine
    import rsca_pkg::*;
#(
    parameter int GRID_WIDTH = GRID_WIDTH_DEFAULT,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_WRITE
    } state_t;

    state_t state_reg;
    logic [ADDR_W-1:0] clr_reg;

    logic               action_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [FILL_W-1:0]  roll_reg;
    logic               in_range_reg;
    logic [1:0]         ox_reg;
    logic [1:0]         oy_reg;
    logic               pend_reg;
    logic               ctr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               before_reg;
    logic               after_reg;

    logic    result_valid_reg;
    result_t result_reg;

    logic [COORD_W:0]   nx;
    logic [COORD_W:0]   ny;
    logic               nbr_ok;
    logic               nbr_ctr;
    logic               scan_last;
    logic [ADDR_W-1:0]  nbr_addr;
    logic [ADDR_W-1:0]  ctr_addr;
    logic               site_ok;
    logic               out_free;
    logic [COUNT_W-1:0] count_fin;
    logic               before_fin;
    logic               after_fin;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    rsca_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign nx = {1'b0, x_reg} + (COORD_W+1)'(ox_reg) - (COORD_W+1)'(1);
    assign ny = {1'b0, y_reg} + (COORD_W+1)'(oy_reg) - (COORD_W+1)'(1);
    assign nbr_ok = !(x_reg == '0 && ox_reg == 2'd0) && !(y_reg == '0 && oy_reg == 2'd0)
                    && (32'(nx) < GRID_WIDTH) && (32'(ny) < GRID_HEIGHT);
    assign nbr_ctr = (ox_reg == 2'd1) && (oy_reg == 2'd1);
    assign scan_last = (action_reg == ACT_SEED) || (ox_reg == 2'd2 && oy_reg == 2'd2);
    assign nbr_addr = ADDR_W'(32'(ny) * GRID_WIDTH + 32'(nx));
    assign ctr_addr = ADDR_W'(32'(y_reg) * GRID_WIDTH + 32'(x_reg));
    assign site_ok = (32'(item.cell_x) < GRID_WIDTH) && (32'(item.cell_y) < GRID_HEIGHT);
    assign out_free = !result_valid_reg || !result_stall;

    assign count_fin = count_reg + COUNT_W'(pend_reg & ram_rdata);
    assign before_fin = ctr_reg ? ram_rdata : before_reg;

    always_comb
    begin
        after_fin = before_fin;
        if (action_reg == ACT_SEED)
        begin
            if (roll_reg < cfg.fill_percent)
            begin
                after_fin = 1'b1;
            end
        end
        else if (!before_fin)
        begin
            after_fin = (cfg.neighbor_threshold < count_fin);
        end
        else
        begin
            after_fin = !(cfg.neighbor_threshold > count_fin);
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = nbr_addr;
        ram_wdata = after_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg;
                ram_wdata = 1'b0;
            end
            ST_WRITE:
            begin
                ram_we = out_free && in_range_reg;
                ram_addr = ctr_addr;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            result_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            ctr_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        action_reg <= item.action;
                        x_reg <= item.cell_x;
                        y_reg <= item.cell_y;
                        roll_reg <= item.roll;
                        in_range_reg <= site_ok;
                        count_reg <= '0;
                        before_reg <= 1'b0;
                        after_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        ctr_reg <= 1'b0;
                        if (item.action == ACT_SEED)
                        begin
                            ox_reg <= 2'd1;
                            oy_reg <= 2'd1;
                        end
                        else
                        begin
                            ox_reg <= 2'd0;
                            oy_reg <= 2'd0;
                        end
                        state_reg <= site_ok ? ST_SCAN : ST_WRITE;
                    end
                end
                ST_SCAN:
                begin
                    count_reg <= count_fin;
                    before_reg <= before_fin;
                    pend_reg <= nbr_ok;
                    ctr_reg <= nbr_ctr;
                    if (ox_reg == 2'd2)
                    begin
                        ox_reg <= 2'd0;
                        oy_reg <= oy_reg + 2'd1;
                    end
                    else
                    begin
                        ox_reg <= ox_reg + 2'd1;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    count_reg <= (action_reg == ACT_UPDATE) ? count_fin : '0;
                    before_reg <= before_fin;
                    after_reg <= after_fin;
                    pend_reg <= 1'b0;
                    ctr_reg <= 1'b0;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        result_reg.cell_after <= after_reg;
                        result_reg.wall_count <= count_reg;
                        result_reg.changed <= after_reg ^ before_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/random_site_cave_automaton.sv
// Cave generator built around a wall grid held in one single-port memory.
// Items arrive on the item channel (valid/stall); each beat is either a seed
// that may set its cell to a wall, or an automaton update of one site.
// Every item yields exactly one beat on the result channel (valid/stall).
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it; they then take effect on the next item.
// An update reads up to nine grid cells one per cycle through the memory's
// single port, then decides and writes the centre back. A seed reads only
// its centre. Sites outside the grid leave the grid as it is. The next item
// is accepted in the same cycle as the result beat at the earliest.
// After reset the block clears all GRID_WIDTH * GRID_HEIGHT cells (4096 by
// default), one cell a cycle, and holds item_stall high meanwhile. A
// finished result sits in an output register, so the next item is accepted
// while the receiver stalls; a second result waits inside the block until
// the first beat has been taken.
`default_nettype none

module random_site_cave_automaton
    import rsca_pkg::*;
#(
    parameter int GRID_WIDTH = GRID_WIDTH_DEFAULT,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    rsca_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    rsca_engine #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

`default_nettype wire
